/* rtl/grs_pkg.sv */
// Package: widths, queue sizing, register indexes, entry types and the round/saturate helper.
`timescale 1ns / 1ps
`default_nettype none
package grs_pkg;

  localparam int W          = 32;
  localparam int PW         = 64;
  localparam int SW         = 66;
  localparam int Q_SHIFT    = 30;
  localparam int QW         = SW - Q_SHIFT;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TAIL    = 2'd1;

  localparam logic signed [W-1:0]  V_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [W-1:0]  V_MIN      = 32'sh8000_0000;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (Q_SHIFT - 1);

  typedef struct packed {
    logic              first;
    logic              last;
    logic              cm;
    logic signed [W-1:0]  xr;
    logic signed [W-1:0]  xi;
    logic signed [W-1:0]  y;
    logic signed [W-1:0]  top_re;
    logic signed [W-1:0]  top_im;
    logic signed [PW-1:0] yz1r;
    logic signed [PW-1:0] yz1i;
    logic signed [PW-1:0] xrz1r;
    logic signed [PW-1:0] xiz1i;
    logic signed [PW-1:0] xrz1i;
    logic signed [PW-1:0] xiz1r;
  } fifo_entry_t;

  typedef struct packed {
    logic              last;
    logic signed [PW-1:0] yz1r;
    logic signed [PW-1:0] yz1i;
    logic signed [PW-1:0] xrz1r;
    logic signed [PW-1:0] xiz1i;
    logic signed [PW-1:0] xrz1i;
    logic signed [PW-1:0] xiz1r;
    logic signed [PW-1:0] xrz2r;
    logic signed [PW-1:0] xiz2i;
    logic signed [PW-1:0] xrz2i;
    logic signed [PW-1:0] xiz2r;
    logic signed [PW-1:0] yz2r;
    logic signed [PW-1:0] yz2i;
  } prod_t;

  typedef struct packed {
    logic signed [W-1:0] val;
    logic                clip;
  } sat_t;

  typedef struct packed {
    logic signed [W-1:0] value_re;
    logic signed [W-1:0] value_im;
    logic                is_entry_zero;
    logic                saturated;
  } result_t;

  function automatic sat_t rnd_sat(input logic signed [SW-1:0] a,
                                   input logic signed [SW-1:0] b,
                                   input logic signed [SW-1:0] c);
    logic signed [SW-1:0] sum;
    logic signed [QW-1:0] q;
    sat_t r;
    sum = a + b + c + ROUND_HALF;
    q = $signed(sum[SW-1:Q_SHIFT]);
    if (q > QW'(V_MAX)) begin
      r.val  = V_MAX;
      r.clip = 1'b1;
    end else if (q < QW'(V_MIN)) begin
      r.val  = V_MIN;
      r.clip = 1'b1;
    end else begin
      r.val  = $signed(q[W-1:0]);
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/grs_if.sv */
// Channel interfaces: input item, result item and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface grs_in_if;
  logic               valid;
  logic               ready;
  logic               first_item;
  logic               last_item;
  logic signed [31:0] top_re;
  logic signed [31:0] top_im;
  logic signed [31:0] rot_x_re;
  logic signed [31:0] rot_x_im;
  logic signed [31:0] rot_y;
  logic signed [31:0] elem_re;
  logic signed [31:0] elem_im;
  modport source (output valid, first_item, last_item, top_re, top_im, rot_x_re,
                  rot_x_im, rot_y, elem_re, elem_im, input ready);
  modport sink (input valid, first_item, last_item, top_re, top_im, rot_x_re,
                rot_x_im, rot_y, elem_re, elem_im, output ready);
endinterface

interface grs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic               is_entry_zero;
  logic               saturated;
  modport source (output valid, value_re, value_im, is_entry_zero, saturated,
                  input ready);
  modport sink (input valid, value_re, value_im, is_entry_zero, saturated,
                output ready);
endinterface

interface grs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_idx;
  logic       wdata;
  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface
`default_nettype wire

/* rtl/grs_front.sv */
// Front end: config registers, input accept, mode masking and carry-free products.
`timescale 1ns / 1ps
`default_nettype none
module grs_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  grs_in_if.sink                    in_ch,
  grs_cfg_if.sink                   cfg_ch,
  input  wire logic                 fifo_full,
  output logic                      wr_en,
  output grs_pkg::fifo_entry_t      wr_data
);
  import grs_pkg::*;

  logic cm_r;
  logic zt_r;

  logic signed [W-1:0] xi;
  logic signed [W-1:0] z1r;
  logic signed [W-1:0] z1i;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !fifo_full;
  assign wr_en        = in_ch.valid && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_r <= 1'b0;
      zt_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_idx)
        CFG_COMPLEX_MODE: cm_r <= cfg_ch.wdata;
        CFG_ZERO_TAIL:    zt_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    xi  = cm_r ? in_ch.rot_x_im : '0;
    z1r = in_ch.elem_re;
    z1i = (cm_r && !(in_ch.first_item && zt_r)) ? in_ch.elem_im : '0;

    wr_data.first  = in_ch.first_item;
    wr_data.last   = in_ch.last_item;
    wr_data.cm     = cm_r;
    wr_data.xr     = in_ch.rot_x_re;
    wr_data.xi     = xi;
    wr_data.y      = in_ch.rot_y;
    wr_data.top_re = zt_r ? '0 : in_ch.top_re;
    wr_data.top_im = (zt_r || !cm_r) ? '0 : in_ch.top_im;
    wr_data.yz1r   = PW'(in_ch.rot_y) * PW'(z1r);
    wr_data.yz1i   = PW'(in_ch.rot_y) * PW'(z1i);
    wr_data.xrz1r  = PW'(in_ch.rot_x_re) * PW'(z1r);
    wr_data.xiz1i  = PW'(xi) * PW'(z1i);
    wr_data.xrz1i  = PW'(in_ch.rot_x_re) * PW'(z1i);
    wr_data.xiz1r  = PW'(xi) * PW'(z1r);
  end

endmodule
`default_nettype wire

/* rtl/grs_fifo.sv */
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module grs_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire grs_pkg::fifo_entry_t wr_data,
  input  wire logic                 rd_en,
  output grs_pkg::fifo_entry_t      head,
  output logic                      head_valid,
  output logic                      full
);
  import grs_pkg::*;

  fifo_entry_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_CW-1:0] count_r;

  assign head       = mem_r[rp_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + FIFO_AW'(1);
      if (rd_en) rp_r <= rp_r + FIFO_AW'(1);
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + FIFO_CW'(1);
        2'b01:   count_r <= count_r - FIFO_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!full || rd_en))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

/* rtl/grs_back.sv */
// Back end: carry products, round/saturate stage, carry register and result slot.
`timescale 1ns / 1ps
`default_nettype none
module grs_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire grs_pkg::fifo_entry_t head,
  input  wire logic                 head_valid,
  output logic                      pop,
  grs_out_if.source                 out_ch
);
  import grs_pkg::*;

  logic signed [W-1:0] carry_re_r, carry_im_r;
  logic                pv_r;
  prod_t               p_r, p_nxt;
  logic                ov_r, hb_r, ph_r;
  result_t             slot_a_r, slot_b_r;

  logic signed [W-1:0] z2r, z2i;
  logic                slot_free, s_fire, out_done;
  sat_t                lr, li, nr, ni;

  assign out_done  = ov_r && out_ch.ready;
  assign slot_free = !ov_r || (out_ch.ready && (ph_r || !hb_r));
  assign s_fire    = pv_r && slot_free;
  assign pop       = head_valid && (!pv_r || (s_fire && head.first));

  always_comb begin
    z2r = head.first ? head.top_re : carry_re_r;
    z2i = head.first ? head.top_im : (head.cm ? carry_im_r : '0);

    p_nxt.last  = head.last;
    p_nxt.yz1r  = head.yz1r;
    p_nxt.yz1i  = head.yz1i;
    p_nxt.xrz1r = head.xrz1r;
    p_nxt.xiz1i = head.xiz1i;
    p_nxt.xrz1i = head.xrz1i;
    p_nxt.xiz1r = head.xiz1r;
    p_nxt.xrz2r = PW'(head.xr) * PW'(z2r);
    p_nxt.xiz2i = PW'(head.xi) * PW'(z2i);
    p_nxt.xrz2i = PW'(head.xr) * PW'(z2i);
    p_nxt.xiz2r = PW'(head.xi) * PW'(z2r);
    p_nxt.yz2r  = PW'(head.y) * PW'(z2r);
    p_nxt.yz2i  = PW'(head.y) * PW'(z2i);
  end

  always_comb begin
    lr = rnd_sat(SW'(p_r.yz1r), -SW'(p_r.xrz2r), SW'(p_r.xiz2i));
    li = rnd_sat(SW'(p_r.yz1i), -SW'(p_r.xrz2i), -SW'(p_r.xiz2r));
    nr = rnd_sat(SW'(p_r.xrz1r), SW'(p_r.xiz1i), SW'(p_r.yz2r));
    ni = rnd_sat(SW'(p_r.xrz1i), -SW'(p_r.xiz1r), SW'(p_r.yz2i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r       <= 1'b0;
      ov_r       <= 1'b0;
      hb_r       <= 1'b0;
      ph_r       <= 1'b0;
      carry_re_r <= '0;
      carry_im_r <= '0;
    end else begin
      if (pop)         pv_r <= 1'b1;
      else if (s_fire) pv_r <= 1'b0;
      if (s_fire) begin
        carry_re_r <= nr.val;
        carry_im_r <= ni.val;
        ov_r       <= 1'b1;
        hb_r       <= p_r.last;
        ph_r       <= 1'b0;
      end else if (out_done) begin
        if (!ph_r && hb_r) begin
          ph_r <= 1'b1;
        end else begin
          ov_r <= 1'b0;
          ph_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) p_r <= p_nxt;
    if (s_fire) begin
      slot_a_r.value_re      <= lr.val;
      slot_a_r.value_im      <= li.val;
      slot_a_r.is_entry_zero <= 1'b0;
      slot_a_r.saturated     <= lr.clip || li.clip;
      slot_b_r.value_re      <= nr.val;
      slot_b_r.value_im      <= ni.val;
      slot_b_r.is_entry_zero <= 1'b1;
      slot_b_r.saturated     <= nr.clip || ni.clip;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.value_re      = ph_r ? slot_b_r.value_re : slot_a_r.value_re;
  assign out_ch.value_im      = ph_r ? slot_b_r.value_im : slot_a_r.value_im;
  assign out_ch.is_entry_zero = ph_r ? slot_b_r.is_entry_zero : slot_a_r.is_entry_zero;
  assign out_ch.saturated     = ph_r ? slot_b_r.saturated : slot_a_r.saturated;

`ifndef NO_ASSERTIONS
  a_carry_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.first) |-> !pv_r)
    else $error("continuing item issued before carry update");
  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r |-> (ov_r && hb_r))
    else $error("entry-zero phase without pending pair");
  a_slot_load: assert property (@(posedge clk) disable iff (!rst_n)
    s_fire |=> (ov_r && !ph_r))
    else $error("result slot not loaded after round stage");
`endif

endmodule
`default_nettype wire

/* rtl/givens_rotation_sweep.sv */
// Top level: front end, item queue and back end of the Givens rotation sweep.
//
//  channel  | dir | transaction                              | handshake
//  in_ch    | in  | one rotation plus element below carry    | valid/ready
//  out_ch   | out | one rotated entry, or entry zero         | valid/ready
//  cfg_ch   | in  | write complex_mode (0) or zero_tail (1)  | valid/ready
//
// Issue: a first_item item can issue as the previous item leaves the product stage; a
// continuing item waits until its predecessor has loaded the carry register through the
// carry multipliers and round/saturate adders. Items pass the queue, product register and
// result slot. A last_item item holds the result slot for two transactions.
// Reset: clears config, carry, queue and stage valids; no clearing pass.
// Stalls: a 4-entry queue and the product stage decouple in_ch from out_ch back-pressure.
`timescale 1ns / 1ps
`default_nettype none
module givens_rotation_sweep (
  input  wire logic clk,
  input  wire logic rst_n,
  grs_in_if.sink    in_ch,
  grs_out_if.source out_ch,
  grs_cfg_if.sink   cfg_ch
);
  import grs_pkg::*;

  fifo_entry_t wr_data, head;
  logic        wr_en, fifo_full, head_valid, pop;

  grs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .fifo_full (fifo_full),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  grs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .rd_en      (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  grs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
